[rtl/core/baro_temp_pressure_compensator_assert.svh]
// Assertion macros used by the checker module.
`ifndef BARO_TEMP_PRESSURE_COMPENSATOR_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATOR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BTPC_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("btpc implication check failed");

// Condition that must hold on every rising clock edge outside reset.
`define BTPC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("btpc invariant check failed");

`endif

[rtl/core/btpc_pkg.sv]
package btpc_pkg;

	// Divider geometry: dividend and divisor widths of the two long divisions.
	localparam int TEMP_NUM_W = 27;
	localparam int TEMP_DEN_W = 20;
	localparam int PRES_NUM_W = 33;
	localparam int PRES_DEN_W = 17;

	localparam int TEMP_SIDE_W = 40;
	localparam int PRES_SIDE_W = 18;

	// Register stages outside the dividers: three before, seven between, four after.
	localparam int LATENCY = 3 + TEMP_NUM_W + 7 + PRES_NUM_W + 4;

	localparam int B6_OFFSET = 4000;
	localparam int B4_BIAS   = 32768;
	localparam int B7_SCALE  = 50000;
	localparam int P_COEF_SQ = 3038;
	localparam int P_COEF_LN = 7357;
	localparam int P_COEF_K  = 3791;
	localparam int PRESS_MAX = 1048575;

	typedef enum logic [2:0] {
		REG_COEFF_A = 3'd0,
		REG_COEFF_B = 3'd1,
		REG_COEFF_C = 3'd2,
		REG_COEFF_D = 3'd3,
		REG_OSS     = 3'd4
	} cfg_reg_t;

endpackage

[rtl/core/baro_temp_pressure_compensator.sv]
// Channel     | Handshake               | Payload
// ------------+-------------------------+-------------------------------------------
// input       | start, busy             | raw_temperature, raw_pressure
// result      | done                    | temperature_tenths, pressure_pa, divide_fault
// config      | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// Fully pipelined: one reading pair can be accepted every cycle, busy stays low.
// Each result appears on done once it has passed through every stage; the two
// bit-serial dividers (27 and 33 stages) make up most of the pipeline depth.
// Reset clears the coefficient registers and all stage valid bits.
// The receiver cannot stall, so the pipeline never holds.
module baro_temp_pressure_compensator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] raw_temperature,
	input  logic [18:0] raw_pressure,
	output logic        done,
	output logic [15:0] temperature_tenths,
	output logic [19:0] pressure_pa,
	output logic        divide_fault,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [47:0] coeff_a_q, coeff_b_q;
	logic [31:0] coeff_c_q, coeff_d_q;
	logic [1:0]  oss_q;

	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic        [15:0] ac4, ac5, ac6;

	assign ac1 = $signed(coeff_a_q[15:0]);
	assign ac2 = $signed(coeff_a_q[31:16]);
	assign ac3 = $signed(coeff_a_q[47:32]);
	assign ac4 = coeff_b_q[15:0];
	assign ac5 = coeff_b_q[31:16];
	assign ac6 = coeff_b_q[47:32];
	assign b1  = $signed(coeff_c_q[15:0]);
	assign b2  = $signed(coeff_c_q[31:16]);
	assign mc  = $signed(coeff_d_q[15:0]);
	assign md  = $signed(coeff_d_q[31:16]);

	// Configuration port.
	logic                wr_en;
	btpc_pkg::cfg_reg_t  reg_sel;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = btpc_pkg::cfg_reg_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= '0;
			coeff_b_q <= '0;
			coeff_c_q <= '0;
			coeff_d_q <= '0;
			oss_q     <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				btpc_pkg::REG_COEFF_A: coeff_a_q <= pwdata[47:0];
				btpc_pkg::REG_COEFF_B: coeff_b_q <= pwdata[47:0];
				btpc_pkg::REG_COEFF_C: coeff_c_q <= pwdata[31:0];
				btpc_pkg::REG_COEFF_D: coeff_d_q <= pwdata[31:0];
				btpc_pkg::REG_OSS:     oss_q     <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			btpc_pkg::REG_COEFF_A: prdata = {16'd0, coeff_a_q};
			btpc_pkg::REG_COEFF_B: prdata = {16'd0, coeff_b_q};
			btpc_pkg::REG_COEFF_C: prdata = {32'd0, coeff_c_q};
			btpc_pkg::REG_COEFF_D: prdata = {32'd0, coeff_d_q};
			btpc_pkg::REG_OSS:     prdata = {62'd0, oss_q};
			default:               prdata = '0;
		endcase
	end

	// Stage valid bits.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic valid_s8, valid_s9, valid_s10, valid_s11, valid_s12, valid_s13, valid_s14;
	logic div_a_valid, div_b_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else begin
			valid_s1  <= start & ~busy;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= div_a_valid;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= div_b_valid;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	// Stages 1 to 3: X1 and the operands of the temperature division.
	logic signed [16:0] diff_s1;
	logic        [18:0] up_s1, up_s2, up_s3;
	logic signed [33:0] prod_s2;

	always_ff @(posedge clk) begin
		diff_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
		up_s1   <= raw_pressure;
		prod_s2 <= diff_s1 * $signed({1'b0, ac5});
		up_s2   <= up_s1;
	end

	logic signed [18:0] x1_t;
	logic signed [19:0] den_t;
	logic signed [26:0] num_t;
	logic        [26:0] num_mag;
	logic        [19:0] den_mag;

	assign x1_t    = $signed(prod_s2[33:15]);
	assign den_t   = 20'(x1_t) + 20'(md);
	assign num_t   = $signed({mc, 11'd0});
	assign num_mag = num_t[26] ? 27'(-num_t) : 27'(num_t);
	assign den_mag = den_t[19] ? 20'(-den_t) : 20'(den_t);

	logic [26:0] num_mag_s3;
	logic [19:0] den_mag_s3;
	logic        neg_s3, zero_s3;
	logic signed [18:0] x1_s3;

	always_ff @(posedge clk) begin
		num_mag_s3 <= num_mag;
		den_mag_s3 <= den_mag;
		neg_s3     <= num_t[26] ^ den_t[19];
		zero_s3    <= (den_t == 20'sd0);
		x1_s3      <= x1_t;
		up_s3      <= up_s2;
	end

	logic [btpc_pkg::TEMP_NUM_W-1:0]  quo_a;
	logic [btpc_pkg::TEMP_SIDE_W-1:0] side_a;

	btpc_div #(
		.NW(btpc_pkg::TEMP_NUM_W),
		.DW(btpc_pkg::TEMP_DEN_W),
		.SW(btpc_pkg::TEMP_SIDE_W)
	) u_div_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.num      (num_mag_s3),
		.den      (den_mag_s3),
		.side_in  ({neg_s3, zero_s3, x1_s3, up_s3}),
		.out_valid(div_a_valid),
		.quo      (quo_a),
		.side_out (side_a)
	);

	// Stage 4: B5 and B6.
	logic               neg_a, zero_a;
	logic signed [18:0] x1_a;
	logic        [18:0] up_a;
	logic signed [27:0] x2_t, b5_t;

	assign neg_a = side_a[39];
	assign zero_a = side_a[38];
	assign x1_a  = $signed(side_a[37:19]);
	assign up_a  = side_a[18:0];
	assign x2_t  = neg_a ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
	assign b5_t  = x2_t + 28'(x1_a);

	logic signed [27:0] b5_s4;
	logic signed [28:0] b6_s4;
	logic               fault_s4, fault_s5, fault_s6, fault_s7, fault_s8, fault_s9;
	logic        [18:0] up_s4, up_s5, up_s6, up_s7;

	always_ff @(posedge clk) begin
		b5_s4    <= b5_t;
		b6_s4    <= 29'(b5_t) - 29'(btpc_pkg::B6_OFFSET);
		fault_s4 <= zero_a;
		up_s4    <= up_a;
	end

	// Stage 5: B6 products and the temperature result.
	logic signed [28:0] t_sum;
	logic signed [24:0] t_wide;
	logic signed [15:0] t_sat;

	assign t_sum  = 29'(b5_s4) + 29'sd8;
	assign t_wide = t_sum[28:4];

	always_comb begin
		if (t_wide > 25'sd32767) begin
			t_sat = 16'sh7FFF;
		end else if (t_wide < -25'sd32768) begin
			t_sat = 16'sh8000;
		end else begin
			t_sat = t_wide[15:0];
		end
	end

	logic signed [57:0] b6sq_s5;
	logic signed [44:0] ac2b6_s5, ac2b6_s6, ac3b6_s5, ac3b6_s6;
	logic signed [15:0] t_s5, t_s6, t_s7, t_s8, t_s9, t_s10;

	always_ff @(posedge clk) begin
		b6sq_s5  <= b6_s4 * b6_s4;
		ac2b6_s5 <= ac2 * b6_s4;
		ac3b6_s5 <= ac3 * b6_s4;
		t_s5     <= t_sat;
		fault_s5 <= fault_s4;
		up_s5    <= up_s4;
	end

	// Stage 6: B2 and B1 terms.
	logic signed [45:0] sq_t;
	logic signed [61:0] b2sq_s6, b1sq_s6;

	assign sq_t = b6sq_s5[57:12];

	always_ff @(posedge clk) begin
		b2sq_s6  <= b2 * sq_t;
		b1sq_s6  <= b1 * sq_t;
		ac2b6_s6 <= ac2b6_s5;
		ac3b6_s6 <= ac3b6_s5;
		t_s6     <= t_s5;
		fault_s6 <= fault_s5;
		up_s6    <= up_s5;
	end

	// Stage 7: B3 before the final quarter, and the B4 multiplicand.
	logic signed [50:0] x1a_t;
	logic signed [33:0] x2a_t;
	logic signed [51:0] x3a_t;
	logic signed [52:0] v_t;
	logic signed [56:0] vsh_t;
	logic signed [31:0] x1b_t;
	logic signed [45:0] x2b_t;
	logic signed [46:0] sb_t;
	logic signed [44:0] x3b_t;

	assign x1a_t = b2sq_s6[61:11];
	assign x2a_t = ac2b6_s6[44:11];
	assign x3a_t = 52'(x1a_t) + 52'(x2a_t);
	assign v_t   = 53'($signed({ac1, 2'b00})) + 53'(x3a_t);
	assign vsh_t = 57'(v_t) <<< oss_q;
	assign x1b_t = ac3b6_s6[44:13];
	assign x2b_t = b1sq_s6[61:16];
	assign sb_t  = 47'(x1b_t) + 47'(x2b_t) + 47'sd2;
	assign x3b_t = sb_t[46:2];

	logic signed [57:0] w_s7;
	logic        [31:0] lo_s7;

	always_ff @(posedge clk) begin
		w_s7     <= 58'(vsh_t) + 58'sd2;
		lo_s7    <= x3b_t[31:0] + 32'(btpc_pkg::B4_BIAS);
		t_s7     <= t_s6;
		fault_s7 <= fault_s6;
		up_s7    <= up_s6;
	end

	// Stage 8: B3 truncated toward zero, B4 product.
	logic signed [57:0] w_adj;
	logic        [31:0] b3_lo;
	logic        [31:0] diff_s8, mul4_s8;

	assign w_adj = w_s7 + (w_s7[57] ? 58'sd3 : 58'sd0);
	assign b3_lo = w_adj[33:2];

	always_ff @(posedge clk) begin
		diff_s8  <= {13'd0, up_s7} - b3_lo;
		mul4_s8  <= 32'(ac4 * lo_s7);
		t_s8     <= t_s7;
		fault_s8 <= fault_s7;
	end

	// Stage 9: B7 and B4.
	logic [15:0] scale;
	logic [31:0] b7_s9;
	logic [16:0] b4_s9;

	assign scale = 16'(btpc_pkg::B7_SCALE >> oss_q);

	always_ff @(posedge clk) begin
		b7_s9    <= 32'(diff_s8 * scale);
		b4_s9    <= mul4_s8[31:15];
		t_s9     <= t_s8;
		fault_s9 <= fault_s8;
	end

	// Stage 10: choose 2*B7/B4 or B7/B4 (doubled afterwards) by the top bit of B7.
	logic [32:0] pnum_s10;
	logic [16:0] pden_s10;
	logic        hi_s10, fault_s10;

	always_ff @(posedge clk) begin
		pnum_s10  <= b7_s9[31] ? {1'b0, b7_s9} : {b7_s9, 1'b0};
		pden_s10  <= b4_s9;
		hi_s10    <= b7_s9[31];
		fault_s10 <= fault_s9 | (b4_s9 == 17'd0);
		t_s10     <= t_s9;
	end

	logic [btpc_pkg::PRES_NUM_W-1:0]  quo_b;
	logic [btpc_pkg::PRES_SIDE_W-1:0] side_b;

	btpc_div #(
		.NW(btpc_pkg::PRES_NUM_W),
		.DW(btpc_pkg::PRES_DEN_W),
		.SW(btpc_pkg::PRES_SIDE_W)
	) u_div_pres (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s10),
		.num      (pnum_s10),
		.den      (pden_s10),
		.side_in  ({hi_s10, fault_s10, t_s10}),
		.out_valid(div_b_valid),
		.quo      (quo_b),
		.side_out (side_b)
	);

	// Stages 11 to 13: the pressure correction products.
	logic [33:0] p_s11, p_s12, p_s13;
	logic        fault_s11, fault_s12, fault_s13;
	logic [15:0] t_s11, t_s12, t_s13;
	logic [51:0] psq_s12;
	logic [46:0] pm_s12, pm_s13;
	logic [63:0] m1_s13;

	always_ff @(posedge clk) begin
		p_s11     <= side_b[17] ? {quo_b, 1'b0} : {1'b0, quo_b};
		fault_s11 <= side_b[16];
		t_s11     <= side_b[15:0];

		psq_s12   <= p_s11[33:8] * p_s11[33:8];
		pm_s12    <= p_s11 * 13'(btpc_pkg::P_COEF_LN);
		p_s12     <= p_s11;
		fault_s12 <= fault_s11;
		t_s12     <= t_s11;

		m1_s13    <= psq_s12 * 12'(btpc_pkg::P_COEF_SQ);
		pm_s13    <= pm_s12;
		p_s13     <= p_s12;
		fault_s13 <= fault_s12;
		t_s13     <= t_s12;
	end

	// Stage 14: final correction, saturation and the fault override.
	logic        [47:0] x1c_t;
	logic signed [47:0] negm_t;
	logic signed [31:0] x2c_t;
	logic signed [49:0] csum_t;
	logic signed [45:0] corr_t;
	logic signed [50:0] pf_t;
	logic        [19:0] p_sat;

	assign x1c_t  = m1_s13[63:16];
	assign negm_t = -$signed({1'b0, pm_s13});
	assign x2c_t  = negm_t[47:16];
	assign csum_t = 50'($signed({1'b0, x1c_t})) + 50'(x2c_t)
		+ 50'(btpc_pkg::P_COEF_K);
	assign corr_t = csum_t[49:4];
	assign pf_t   = 51'($signed({1'b0, p_s13})) + 51'(corr_t);

	always_comb begin
		if (pf_t < 51'sd0) begin
			p_sat = '0;
		end else if (pf_t > 51'(btpc_pkg::PRESS_MAX)) begin
			p_sat = 20'(btpc_pkg::PRESS_MAX);
		end else begin
			p_sat = pf_t[19:0];
		end
	end

	logic [15:0] temp_s14;
	logic [19:0] pres_s14;
	logic        fault_s14;

	always_ff @(posedge clk) begin
		temp_s14  <= fault_s13 ? 16'd0 : t_s13;
		pres_s14  <= fault_s13 ? 20'd0 : p_sat;
		fault_s14 <= fault_s13;
	end

	assign done               = valid_s14;
	assign temperature_tenths = temp_s14;
	assign pressure_pa        = pres_s14;
	assign divide_fault       = fault_s14;

endmodule

[rtl/core/btpc_div.sv]
// Unsigned restoring divider, one quotient bit per register stage.
module btpc_div #(
	parameter int NW = btpc_pkg::TEMP_NUM_W,
	parameter int DW = btpc_pkg::TEMP_DEN_W,
	parameter int SW = btpc_pkg::TEMP_SIDE_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic          stg_valid_s [0:NW];
	logic [DW-1:0] rem_s       [0:NW];
	logic [NW-1:0] num_s       [0:NW];
	logic [DW-1:0] den_s       [0:NW];
	logic [SW-1:0] side_s      [0:NW];

	assign stg_valid_s[0] = in_valid;
	assign rem_s[0]       = '0;
	assign num_s[0]       = num;
	assign den_s[0]       = den;
	assign side_s[0]      = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW+1:0] trial;

		// The top bit of the trial subtraction is the borrow.
		assign trial = {1'b0, rem_s[k], num_s[k][NW-1]} - {2'b00, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_valid_s[k+1] <= 1'b0;
			end else begin
				stg_valid_s[k+1] <= stg_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (!trial[DW+1]) begin
				rem_s[k+1] <= trial[DW-1:0];
				num_s[k+1] <= {num_s[k][NW-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= {rem_s[k][DW-2:0], num_s[k][NW-1]};
				num_s[k+1] <= {num_s[k][NW-2:0], 1'b0};
			end
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = stg_valid_s[NW];
	assign quo       = num_s[NW];
	assign side_out  = side_s[NW];

endmodule

[rtl/core/btpc_checker.sv]
`include "baro_temp_pressure_compensator_assert.svh"

module btpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] temperature_tenths,
	input logic [19:0] pressure_pa,
	input logic        divide_fault,
	input logic        pready
);

	// Every accepted transfer yields exactly one result on done, and done never rises without one.
	`BTPC_ASSERT_IMPL(a_result_follows, start && !busy, ##(btpc_pkg::LATENCY) done)
	`BTPC_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, btpc_pkg::LATENCY))
	// A divide fault forces both result fields to zero.
	`BTPC_ASSERT_IMPL(a_fault_zero, done && divide_fault,
		temperature_tenths == 16'd0 && pressure_pa == 20'd0)
	`BTPC_ASSERT_ALWAYS(a_pready_high, pready && !busy)

endmodule

bind baro_temp_pressure_compensator btpc_checker u_btpc_checker (.*);
